// File: src/pci_pkg.sv
// ----------------------------------------------------------------------------
// pci_pkg: shared types and constants of the palette colour indexer
// Holds the palette geometry and the probe and write word types of the cell row.
// ----------------------------------------------------------------------------
package pci_pkg;

  localparam int PALETTE_ENTRIES = 255;              // index 0 reserved
  localparam int NUM_CELLS       = PALETTE_ENTRIES - 1;
  localparam int IDX_W           = 8;
  localparam int RGB_W           = 24;
  localparam int THR_W           = 8;

  localparam logic [IDX_W-1:0] IDX_TRANSPARENT = 8'h00;
  localparam logic [IDX_W-1:0] IDX_FULL        = 8'hFF;
  localparam logic [THR_W-1:0] THRESHOLD_RESET = 8'h7F;
  localparam logic [IDX_W-1:0] COUNT_RESET     = 8'h01;
  localparam logic [IDX_W-1:0] COUNT_LIMIT     = IDX_W'(PALETTE_ENTRIES);

  // Colour probe walking down the row of cells
  typedef struct packed {
    logic             vld;
    logic [RGB_W-1:0] rgb;
    logic             hit;
    logic [IDX_W-1:0] idx;
  } probe_t;

  // Broadcast write of a new palette entry
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [RGB_W-1:0] rgb;
  } wr_t;

endpackage

// File: src/palette_color_indexer_unit.sv
// ----------------------------------------------------------------------------
// palette_color_indexer_unit: dynamic palette colour indexer
// Maps each RGBA pixel to a palette index, adding unseen colours on the fly.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------
//  in_     | in  | in_tvalid/in_tready  | red, green, blue, alpha
//  out_    | out | out_tvalid/out_tready| color_index, entry_added, palette_full
//  cfg_    | in  | cfg_valid/cfg_ready  | alpha_threshold
//
//  Opaque pixels walk the row of NUM_CELLS cells, one cell per cycle, so the
//  walk length is the same whatever the fill of the palette; the length of
//  the cell row sets it. Transparent pixels skip the walk and go straight to
//  the push state. One pixel is in flight at a time. Reset sets the threshold
//  to 0x7F and the entry count to 1; no clearing pass. A stalled output holds
//  the result; the next pixel may still be taken.
//
module palette_color_indexer_unit
  import pci_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // pixel input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [7:0] red, [15:8] green, [23:16] blue,
                                   // [31:24] alpha
  // index output
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [7:0] color_index, [8] entry_added,
                                   // [9] palette_full, [15:10] zero
  // threshold register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,   // wait for a pixel
    S_WALK = 3'b010,   // probe travelling down the cell row
    S_PUSH = 3'b100    // hand the result to the output register
  } state_t;

  state_t state_r, state_nxt;

  logic [THR_W-1:0] thr_r;
  logic [IDX_W-1:0] count_r, count_nxt;

  logic [IDX_W-1:0] res_idx_r, res_idx_nxt;
  logic             res_add_r, res_add_nxt;
  logic             res_full_r, res_full_nxt;

  logic             out_vld_r, out_vld_nxt;
  logic [IDX_W-1:0] out_idx_r;
  logic             out_add_r;
  logic             out_full_r;

  logic             in_acc;
  logic             opaque;
  logic             walk_done;
  logic             load_out;
  logic             room;

  probe_t           chain [0:NUM_CELLS];
  wr_t              wr;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign opaque    = (in_tdata[31:24] >= thr_r);
  assign cfg_ready = 1'b1;

  // Launch an opaque pixel into the first cell
  assign chain[0] = '{vld: in_acc && opaque, rgb: in_tdata[23:0], hit: 1'b0,
                      idx: IDX_TRANSPARENT};

  genvar k;
  generate
    for (k = 0; k < NUM_CELLS; k++) begin : g_cell
      pci_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .cell_idx  (IDX_W'(k + 1)),
        .count     (count_r),
        .wr        (wr),
        .probe_in  (chain[k]),
        .probe_out (chain[k+1])
      );
    end
  endgenerate

  assign walk_done = (state_r == S_WALK) && chain[NUM_CELLS].vld;
  assign room      = (count_r < COUNT_LIMIT);

  // Store a new colour at the next free index on a miss with room left
  always_comb begin
    wr.en  = walk_done && !chain[NUM_CELLS].hit && room;
    wr.idx = count_r;
    wr.rgb = chain[NUM_CELLS].rgb;
  end

  assign load_out = (state_r == S_PUSH) && (!out_vld_r || out_tready);

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    res_idx_nxt  = res_idx_r;
    res_add_nxt  = res_add_r;
    res_full_nxt = res_full_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (opaque) begin
            state_nxt = S_WALK;
          end else begin
            res_idx_nxt  = IDX_TRANSPARENT;
            res_add_nxt  = 1'b0;
            res_full_nxt = 1'b0;
            state_nxt    = S_PUSH;
          end
        end
      end
      S_WALK: begin
        if (walk_done) begin
          state_nxt = S_PUSH;
          if (chain[NUM_CELLS].hit) begin
            res_idx_nxt  = chain[NUM_CELLS].idx;
            res_add_nxt  = 1'b0;
            res_full_nxt = 1'b0;
          end else if (room) begin
            res_idx_nxt  = count_r;
            res_add_nxt  = 1'b1;
            res_full_nxt = 1'b0;
            count_nxt    = count_r + 1'b1;
          end else begin
            res_idx_nxt  = IDX_FULL;
            res_add_nxt  = 1'b0;
            res_full_nxt = 1'b1;
          end
        end
      end
      S_PUSH: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register: load a finished result, drop it once taken
  always_comb begin
    if (load_out) begin
      out_vld_nxt = 1'b1;
    end else if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= COUNT_RESET;
      thr_r     <= THRESHOLD_RESET;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_idx_r  <= res_idx_nxt;
    res_add_r  <= res_add_nxt;
    res_full_r <= res_full_nxt;
    if (load_out) begin
      out_idx_r  <= res_idx_r;
      out_add_r  <= res_add_r;
      out_full_r <= res_full_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'b0, out_full_r, out_add_r, out_idx_r};

endmodule

// File: src/pci_cell.sv
// ----------------------------------------------------------------------------
// pci_cell: one palette entry of the indexer row
// Stores one RGB entry, compares the passing probe and hands it on.
// ----------------------------------------------------------------------------
module pci_cell
  import pci_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] cell_idx,   // fixed palette index of this cell
  input  logic [IDX_W-1:0] count,      // next free palette index
  input  wr_t              wr,
  input  probe_t           probe_in,
  output probe_t           probe_out
);

  logic [RGB_W-1:0] entry_r;
  probe_t           probe_r;
  logic             in_use;
  logic             match;

  assign in_use    = (cell_idx < count);
  assign match     = probe_in.vld && in_use && (entry_r == probe_in.rgb);
  assign probe_out = probe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r.vld <= 1'b0;
    end else begin
      probe_r.vld <= probe_in.vld;
    end
    probe_r.rgb <= probe_in.rgb;
    probe_r.hit <= probe_in.hit | match;
    probe_r.idx <= match ? cell_idx : probe_in.idx;
    if (wr.en && (wr.idx == cell_idx)) begin
      entry_r <= wr.rgb;
    end
  end

endmodule
